@@ rtl/adp_pkg.sv @@
`timescale 1ns / 1ps
package adp_pkg;

  typedef enum logic [7:0] {
    PH_HEADER = 8'b0000_0001,
    PH_COUNT  = 8'b0000_0010,
    PH_NLEN   = 8'b0000_0100,
    PH_NAME   = 8'b0000_1000,
    PH_OFFSET = 8'b0001_0000,
    PH_SIZE   = 8'b0010_0000,
    PH_RESV   = 8'b0100_0000,
    PH_BODY   = 8'b1000_0000
  } phase_e;

  typedef logic [2:0] role_t;
  typedef logic [2:0] err_t;

  localparam role_t ROLE_HEADER = 3'd0;
  localparam role_t ROLE_COUNT  = 3'd1;
  localparam role_t ROLE_NLEN   = 3'd2;
  localparam role_t ROLE_NAME   = 3'd3;
  localparam role_t ROLE_OFFSET = 3'd4;
  localparam role_t ROLE_SIZE   = 3'd5;
  localparam role_t ROLE_RESV   = 3'd6;
  localparam role_t ROLE_BODY   = 3'd7;

  localparam err_t ERR_NONE      = 3'd0;
  localparam err_t ERR_MAGIC     = 3'd1;
  localparam err_t ERR_COUNT     = 3'd2;
  localparam err_t ERR_NAME_LEN  = 3'd3;
  localparam err_t ERR_BOUNDS    = 3'd4;
  localparam err_t ERR_TRUNCATED = 3'd5;

  localparam logic [7:0] CFG_KEY_SEED       = 8'd0;
  localparam logic [7:0] CFG_ARCHIVE_LENGTH = 8'd1;
  localparam logic [7:0] CFG_MAX_ENTRIES    = 8'd2;
  localparam logic [7:0] CFG_MAX_NAME_LEN   = 8'd3;

  localparam logic [63:0] SEED_RESET        = 64'h7F23_BBE3_8FA1_2345;
  localparam logic [63:0] ARCHIVE_LEN_RESET = 64'd0;
  localparam logic [31:0] MAX_ENTRIES_RESET = 32'd10000;
  localparam logic [15:0] MAX_NAME_RESET    = 16'd1024;
  localparam logic [31:0] MAGIC_WORD        = 32'h4341_5044;

  function automatic role_t phase_role(phase_e ph);
    role_t r;
    unique case (ph)
      PH_HEADER: r = ROLE_HEADER;
      PH_COUNT:  r = ROLE_COUNT;
      PH_NLEN:   r = ROLE_NLEN;
      PH_NAME:   r = ROLE_NAME;
      PH_OFFSET: r = ROLE_OFFSET;
      PH_SIZE:   r = ROLE_SIZE;
      PH_RESV:   r = ROLE_RESV;
      default:   r = ROLE_BODY;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/archive_decrypt_directory_parser_core.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+----------------------------------------
// in       | sink      | in_valid_i / in_stall_o | data_byte_i, archive_start_i
// out      | source    | out_valid_o/out_stall_i | plain_byte_o .. directory_done_o
// cfg      | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word per cycle unless in_stall_o is high; each result is registered on acceptance.
// The keystream step and parser state update are combinational, which sets the rate.
// Input stalls only while a result is held and out_stall_i is high.
// rst_ni clears the parser and loads register defaults; cfg_ready_o is always high.
module archive_decrypt_directory_parser_core
  import adp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        archive_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  plain_byte_o,
  output logic [2:0]  byte_role_o,
  output logic        entry_ready_o,
  output logic [31:0] entry_index_o,
  output logic [15:0] entry_name_length_o,
  output logic [63:0] entry_offset_o,
  output logic [63:0] entry_size_o,
  output logic [2:0]  error_code_o,
  output logic        directory_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0] key_seed_q, archive_len_q;
  logic [31:0] max_entries_q;
  logic [15:0] max_name_q;

  logic [63:0] keystream_q, keystream_d;
  logic [63:0] pos_q, pos_d;
  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] acc_q, acc_d;
  logic [15:0] nleft_q, nleft_d;
  logic [15:0] nheld_q, nheld_d;
  logic [31:0] eleft_q, eleft_d;
  logic [31:0] idx_q, idx_d;
  logic [63:0] hoff_q, hoff_d;
  logic [63:0] hsize_q, hsize_d;
  err_t        err_q, err_d;

  logic        out_valid_q;
  logic [7:0]  plain_q;
  role_t       role_q;
  logic        ready_q;
  logic [31:0] oidx_q;
  logic [15:0] onlen_q;
  logic [63:0] ooff_q, osize_q;
  err_t        oerr_q;
  logic        odone_q;

  logic        accept;
  logic [63:0] ks_b, ks1, ks2, ks3;
  logic [63:0] pos_b, acc_b, hoff_b, hsize_b, acc_wr;
  phase_e      phase_b;
  logic [3:0]  cnt_b, cnt_inc;
  logic [15:0] nleft_b, nheld_b, need_len, nleft_dec;
  logic [31:0] eleft_b, idx_b, eleft_dec;
  err_t        err_b;
  logic [64:0] remain, bound_sum;
  logic        fits, ready;
  logic [7:0]  plain;

  assign accept      = in_valid_i & ~in_stall_o;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    ks_b    = archive_start_i ? key_seed_q : keystream_q;
    pos_b   = archive_start_i ? 64'd0 : pos_q;
    phase_b = archive_start_i ? PH_HEADER : phase_q;
    cnt_b   = archive_start_i ? 4'd0 : cnt_q;
    acc_b   = archive_start_i ? 64'd0 : acc_q;
    nleft_b = archive_start_i ? 16'd0 : nleft_q;
    nheld_b = archive_start_i ? 16'd0 : nheld_q;
    eleft_b = archive_start_i ? 32'd0 : eleft_q;
    idx_b   = archive_start_i ? 32'd0 : idx_q;
    hoff_b  = archive_start_i ? 64'd0 : hoff_q;
    hsize_b = archive_start_i ? 64'd0 : hsize_q;
    err_b   = archive_start_i ? ERR_NONE : err_q;

    ks1   = ks_b ^ (ks_b >> 12);
    ks2   = ks1 ^ (ks1 << 25);
    ks3   = ks2 ^ (ks2 >> 27);
    plain = data_byte_i ^ ks3[7:0];

    unique case (phase_b)
      PH_COUNT, PH_HEADER, PH_RESV: need_len = 16'd4;
      PH_NLEN:                      need_len = 16'd2;
      PH_NAME:                      need_len = nheld_b;
      PH_OFFSET, PH_SIZE:           need_len = 16'd8;
      default:                      need_len = 16'd0;
    endcase
    remain = {1'b0, archive_len_q} - {1'b0, pos_b};
    fits   = ~remain[64] & (remain[63:0] >= {48'd0, need_len});

    acc_wr    = acc_b | ({56'd0, plain} << {cnt_b[2:0], 3'b000});
    cnt_inc   = cnt_b + 4'd1;
    nleft_dec = (nleft_b != 16'd0) ? nleft_b - 16'd1 : nleft_b;
    eleft_dec = (eleft_b != 32'd0) ? eleft_b - 32'd1 : eleft_b;
    bound_sum = {1'b0, hoff_b} + {1'b0, hsize_b};

    keystream_d = ks3;
    pos_d       = pos_b + 64'd1;
    phase_d     = phase_b;
    cnt_d       = cnt_b;
    acc_d       = acc_b;
    nleft_d     = nleft_b;
    nheld_d     = nheld_b;
    eleft_d     = eleft_b;
    idx_d       = idx_b;
    hoff_d      = hoff_b;
    hsize_d     = hsize_b;
    err_d       = err_b;
    ready       = 1'b0;

    unique case (phase_b)
      PH_HEADER: begin
        if ((cnt_b == 4'd0 || cnt_b == 4'd4) && !fits) begin
          err_d = ERR_TRUNCATED; phase_d = PH_BODY;
        end else if (cnt_inc == 4'd4 && acc_wr[31:0] != MAGIC_WORD) begin
          acc_d = acc_wr; cnt_d = cnt_inc;
          err_d = ERR_MAGIC; phase_d = PH_BODY;
        end else if (cnt_inc >= 4'd8) begin
          phase_d = PH_COUNT; cnt_d = 4'd0; acc_d = 64'd0;
        end else begin
          acc_d = acc_wr; cnt_d = cnt_inc;
        end
      end
      PH_COUNT: begin
        if (cnt_b == 4'd0 && !fits) begin
          err_d = ERR_TRUNCATED; phase_d = PH_BODY;
        end else if (cnt_inc >= 4'd4) begin
          if (acc_wr[31:0] > max_entries_q) begin
            acc_d = acc_wr; cnt_d = cnt_inc;
            err_d = ERR_COUNT; phase_d = PH_BODY;
          end else begin
            eleft_d = acc_wr[31:0];
            idx_d   = 32'd0;
            phase_d = (acc_wr[31:0] == 32'd0) ? PH_BODY : PH_NLEN;
            cnt_d   = 4'd0; acc_d = 64'd0;
          end
        end else begin
          acc_d = acc_wr; cnt_d = cnt_inc;
        end
      end
      PH_NLEN: begin
        if (cnt_b == 4'd0 && !fits) begin
          err_d = ERR_TRUNCATED; phase_d = PH_BODY;
        end else if (cnt_inc >= 4'd2) begin
          if (acc_wr[15:0] == 16'd0 || acc_wr[15:0] > max_name_q) begin
            acc_d = acc_wr; cnt_d = cnt_inc;
            err_d = ERR_NAME_LEN; phase_d = PH_BODY;
          end else begin
            nheld_d = acc_wr[15:0];
            nleft_d = acc_wr[15:0];
            phase_d = PH_NAME; cnt_d = 4'd0; acc_d = 64'd0;
          end
        end else begin
          acc_d = acc_wr; cnt_d = cnt_inc;
        end
      end
      PH_NAME: begin
        if (nleft_b == nheld_b && !fits) begin
          err_d = ERR_TRUNCATED; phase_d = PH_BODY;
        end else begin
          nleft_d = nleft_dec;
          if (nleft_dec == 16'd0) begin
            phase_d = PH_OFFSET; cnt_d = 4'd0; acc_d = 64'd0;
          end
        end
      end
      PH_OFFSET, PH_SIZE: begin
        if (cnt_b == 4'd0 && !fits) begin
          err_d = ERR_TRUNCATED; phase_d = PH_BODY;
        end else if (cnt_inc >= 4'd8) begin
          if (phase_b == PH_OFFSET) begin
            hoff_d = acc_wr; phase_d = PH_SIZE;
          end else begin
            hsize_d = acc_wr; phase_d = PH_RESV;
          end
          cnt_d = 4'd0; acc_d = 64'd0;
        end else begin
          acc_d = acc_wr; cnt_d = cnt_inc;
        end
      end
      PH_RESV: begin
        if (cnt_b == 4'd0 && !fits) begin
          err_d = ERR_TRUNCATED; phase_d = PH_BODY;
        end else if (cnt_inc >= 4'd4) begin
          if (bound_sum[64] || bound_sum[63:0] > archive_len_q) begin
            acc_d = acc_wr; cnt_d = cnt_inc;
            err_d = ERR_BOUNDS; phase_d = PH_BODY;
          end else begin
            ready   = 1'b1;
            idx_d   = idx_b + 32'd1;
            eleft_d = eleft_dec;
            phase_d = (eleft_dec == 32'd0) ? PH_BODY : PH_NLEN;
            cnt_d   = 4'd0; acc_d = 64'd0;
          end
        end else begin
          acc_d = acc_wr; cnt_d = cnt_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_seed_q    <= SEED_RESET;
      archive_len_q <= ARCHIVE_LEN_RESET;
      max_entries_q <= MAX_ENTRIES_RESET;
      max_name_q    <= MAX_NAME_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KEY_SEED:       key_seed_q    <= cfg_data_i;
        CFG_ARCHIVE_LENGTH: archive_len_q <= cfg_data_i;
        CFG_MAX_ENTRIES:    max_entries_q <= cfg_data_i[31:0];
        CFG_MAX_NAME_LEN:   max_name_q    <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keystream_q <= SEED_RESET;
      pos_q       <= 64'd0;
      phase_q     <= PH_HEADER;
      cnt_q       <= 4'd0;
      acc_q       <= 64'd0;
      nleft_q     <= 16'd0;
      nheld_q     <= 16'd0;
      eleft_q     <= 32'd0;
      idx_q       <= 32'd0;
      hoff_q      <= 64'd0;
      hsize_q     <= 64'd0;
      err_q       <= ERR_NONE;
    end else if (accept) begin
      keystream_q <= keystream_d;
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      nleft_q     <= nleft_d;
      nheld_q     <= nheld_d;
      eleft_q     <= eleft_d;
      idx_q       <= idx_d;
      hoff_q      <= hoff_d;
      hsize_q     <= hsize_d;
      err_q       <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      plain_q <= plain;
      role_q  <= phase_role(phase_b);
      ready_q <= ready;
      oidx_q  <= idx_b;
      onlen_q <= ready ? nheld_b : 16'd0;
      ooff_q  <= ready ? hoff_b : 64'd0;
      osize_q <= ready ? hsize_b : 64'd0;
      oerr_q  <= err_d;
      odone_q <= (phase_d == PH_BODY) && (err_d == ERR_NONE);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign plain_byte_o        = plain_q;
  assign byte_role_o         = role_q;
  assign entry_ready_o       = ready_q;
  assign entry_index_o       = oidx_q;
  assign entry_name_length_o = onlen_q;
  assign entry_offset_o      = ooff_q;
  assign entry_size_o        = osize_q;
  assign error_code_o        = oerr_q;
  assign directory_done_o    = odone_q;

endmodule

@@ rtl/adp_checker.sv @@
`timescale 1ns / 1ps
module adp_checker
  import adp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  plain_byte_o,
  input logic [2:0]  byte_role_o,
  input logic        entry_ready_o,
  input logic [2:0]  error_code_o,
  input logic        directory_done_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(plain_byte_o)
      && $stable(byte_role_o))
    else $error("result word changed while stalled");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free result register");

  a_ready_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_ready_o |-> error_code_o == ERR_NONE && byte_role_o == ROLE_RESV)
    else $error("entry reported with error or outside reserved field");

  a_done_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && directory_done_o |-> error_code_o == ERR_NONE)
    else $error("directory done with error set");

  a_error_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> error_code_o <= ERR_TRUNCATED)
    else $error("error code out of range");

endmodule

bind archive_decrypt_directory_parser_core adp_checker u_adp_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
import adp_pkg::*;

typedef struct packed {
  logic [7:0]  plain;
  role_t       role;
  logic        ready;
  logic [31:0] index;
  logic [15:0] nlen;
  logic [63:0] offset;
  logic [63:0] size;
  err_t        err;
  logic        done;
} parse_word_t;

class archive_checker;
  logic [63:0] seed_r;
  logic [63:0] alen_r;
  logic [31:0] max_cnt_r;
  logic [15:0] max_nlen_r;

  logic [63:0] ks;
  logic [63:0] pos;
  logic [63:0] acc;
  logic [63:0] off_h;
  logic [63:0] size_h;
  role_t       phase;
  int unsigned fcnt;
  logic [15:0] name_left;
  logic [15:0] nlen_h;
  logic [31:0] ents_left;
  logic [31:0] cur_idx;
  err_t        err;

  parse_word_t parsed_q[$];
  int unsigned mismatches;
  int unsigned entries_seen;
  logic [7:0]  codes_seen;

  function new();
    seed_r       = SEED_RESET;
    alen_r       = ARCHIVE_LEN_RESET;
    max_cnt_r    = MAX_ENTRIES_RESET;
    max_nlen_r   = MAX_NAME_RESET;
    ks           = SEED_RESET;
    mismatches   = 0;
    entries_seen = 0;
    codes_seen   = '0;
    clear();
  endfunction

  function void clear();
    pos       = '0;
    phase     = ROLE_HEADER;
    fcnt      = 0;
    acc       = '0;
    name_left = '0;
    nlen_h    = '0;
    ents_left = '0;
    cur_idx   = '0;
    off_h     = '0;
    size_h    = '0;
    err       = ERR_NONE;
  endfunction

  function void set_reg(logic [7:0] idx, logic [63:0] v);
    case (idx)
      CFG_KEY_SEED:       seed_r = v;
      CFG_ARCHIVE_LENGTH: alen_r = v;
      CFG_MAX_ENTRIES:    max_cnt_r = v[31:0];
      CFG_MAX_NAME_LEN:   max_nlen_r = v[15:0];
      default: ;
    endcase
  endfunction

  function logic [63:0] xorshift(logic [63:0] s);
    s ^= s >> 12;
    s ^= s << 25;
    s ^= s >> 27;
    return s;
  endfunction

  function bit fits(logic [63:0] n);
    return (pos <= alen_r) && (alen_r - pos >= n);
  endfunction

  function void abort(err_t code);
    err   = code;
    phase = ROLE_BODY;
  endfunction

  function void next_field(role_t p);
    phase = p;
    fcnt  = 0;
    acc   = '0;
  endfunction

  function bit gather(logic [7:0] b, int unsigned len);
    if (fcnt == 0 && !fits(64'(len))) begin
      abort(ERR_TRUNCATED);
      return 1'b0;
    end
    acc |= {56'd0, b} << (8 * fcnt);
    fcnt++;
    return fcnt >= len;
  endfunction

  function void note_byte(logic [7:0] data, logic start);
    parse_word_t w;
    logic [63:0] v;
    w = '0;
    if (start) begin
      ks = seed_r;
      clear();
    end
    ks      = xorshift(ks);
    w.plain = data ^ ks[7:0];
    w.role  = phase;
    w.index = cur_idx;
    case (phase)
      ROLE_HEADER: begin
        if ((fcnt == 0 || fcnt == 4) && !fits(64'd4)) begin
          abort(ERR_TRUNCATED);
        end else begin
          acc |= {56'd0, w.plain} << (8 * fcnt);
          fcnt++;
          if (fcnt == 4 && acc[31:0] != MAGIC_WORD) begin
            abort(ERR_MAGIC);
          end else if (fcnt >= 8) begin
            next_field(ROLE_COUNT);
          end
        end
      end
      ROLE_COUNT: begin
        if (gather(w.plain, 4)) begin
          if (acc[31:0] > max_cnt_r) begin
            abort(ERR_COUNT);
          end else begin
            ents_left = acc[31:0];
            cur_idx   = '0;
            next_field((acc[31:0] == 0) ? ROLE_BODY : ROLE_NLEN);
          end
        end
      end
      ROLE_NLEN: begin
        if (gather(w.plain, 2)) begin
          if (acc[15:0] == 0 || acc[15:0] > max_nlen_r) begin
            abort(ERR_NAME_LEN);
          end else begin
            nlen_h    = acc[15:0];
            name_left = acc[15:0];
            next_field(ROLE_NAME);
          end
        end
      end
      ROLE_NAME: begin
        if (name_left == nlen_h && !fits({48'd0, nlen_h})) begin
          abort(ERR_TRUNCATED);
        end else begin
          if (name_left > 0) name_left--;
          if (name_left == 0) next_field(ROLE_OFFSET);
        end
      end
      ROLE_OFFSET: begin
        if (gather(w.plain, 8)) begin
          off_h = acc;
          next_field(ROLE_SIZE);
        end
      end
      ROLE_SIZE: begin
        if (gather(w.plain, 8)) begin
          size_h = acc;
          next_field(ROLE_RESV);
        end
      end
      ROLE_RESV: begin
        if (gather(w.plain, 4)) begin
          v = off_h + size_h;
          if (v < off_h || v > alen_r) begin
            abort(ERR_BOUNDS);
          end else begin
            w.ready  = 1'b1;
            w.nlen   = nlen_h;
            w.offset = off_h;
            w.size   = size_h;
            cur_idx++;
            if (ents_left > 0) ents_left--;
            next_field((ents_left == 0) ? ROLE_BODY : ROLE_NLEN);
          end
        end
      end
      default: ;
    endcase
    pos    = pos + 1;
    w.err  = err;
    w.done = (phase == ROLE_BODY) && (err == ERR_NONE);
    parsed_q.push_back(w);
  endfunction

  function int pending();
    return parsed_q.size();
  endfunction

  function void cmp(string field, logic [63:0] e, logic [63:0] a);
    if (a !== e) begin
      $display("%0t: %s expected %h got %h", $time, field, e, a);
      mismatches++;
    end
  endfunction

  function void check_result(parse_word_t got);
    parse_word_t w;
    if (parsed_q.size() == 0) begin
      $display("%0t: word with nothing expected, plain_byte %h", $time, got.plain);
      mismatches++;
      return;
    end
    w = parsed_q.pop_front();
    cmp("plain_byte", 64'(w.plain), 64'(got.plain));
    cmp("byte_role", 64'(w.role), 64'(got.role));
    cmp("entry_ready", 64'(w.ready), 64'(got.ready));
    cmp("entry_index", 64'(w.index), 64'(got.index));
    cmp("entry_name_length", 64'(w.nlen), 64'(got.nlen));
    cmp("entry_offset", w.offset, got.offset);
    cmp("entry_size", w.size, got.size);
    cmp("error_code", 64'(w.err), 64'(got.err));
    cmp("directory_done", 64'(w.done), 64'(got.done));
    if (w.ready) entries_seen++;
    codes_seen[w.err] = 1'b1;
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_BYTES = 1050;

  typedef enum int {
    ARC_BAD_MAGIC,
    ARC_BAD_COUNT,
    ARC_BAD_NAME_LEN,
    ARC_HUGE_NAME,
    ARC_BOUNDS,
    ARC_NOISE,
    ARC_CLEAN
  } arc_kind_e;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        archive_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  plain_byte_o;
  logic [2:0]  byte_role_o;
  logic        entry_ready_o;
  logic [31:0] entry_index_o;
  logic [15:0] entry_name_length_o;
  logic [63:0] entry_offset_o;
  logic [63:0] entry_size_o;
  logic [2:0]  error_code_o;
  logic        directory_done_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  archive_checker sb = new();

  logic [7:0]  plain_q[$];
  bit          steady = 1'b0;
  int          hold_request = 0;
  int unsigned bytes_sent = 0;
  int unsigned archives = 0;
  int unsigned settings = 0;
  int unsigned cycle_count = 0;

  archive_decrypt_directory_parser_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) plain_q.push_back(v[8*i +: 8]);
  endtask

  task automatic push_noise(input int n);
    repeat (n) plain_q.push_back(8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    bit hit;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    archive_start_i <= first;
    do begin
      @(negedge clk_i);
      hit = !in_stall_o;
      @(posedge clk_i);
    end while (!hit);
    sb.note_byte(b, first);
    bytes_sent++;
  endtask

  task automatic send_archive();
    logic [63:0] k;
    k = sb.seed_r;
    for (int i = 0; i < plain_q.size(); i++) begin
      k = sb.xorshift(k);
      send_byte(plain_q[i] ^ k[7:0], i == 0);
    end
    archives++;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
    bit hit;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      hit = cfg_ready_o;
      @(posedge clk_i);
    end while (!hit);
    cfg_valid_i <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic build_archive(input arc_kind_e kind);
    int          n_ent;
    int          hi;
    logic [31:0] cnt;
    logic [15:0] nl;
    logic [63:0] t;
    logic [63:0] sz;
    logic [63:0] off;
    plain_q.delete();
    if (kind == ARC_NOISE) begin
      push_noise($urandom_range(1, 8));
      return;
    end
    push_le(64'(MAGIC_WORD), 4);
    if (kind == ARC_BAD_MAGIC) begin
      plain_q[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
      push_noise($urandom_range(0, 3));
      return;
    end
    push_le(rand64(), 4);
    n_ent = $urandom_range(0, 3);
    if (kind inside {ARC_BAD_NAME_LEN, ARC_HUGE_NAME, ARC_BOUNDS} && n_ent == 0) n_ent = 1;
    if (n_ent > sb.max_cnt_r) n_ent = int'(sb.max_cnt_r);
    if (kind == ARC_BAD_COUNT) begin
      cnt = (sb.max_cnt_r > 32'hFFFF_FFF0) ? 32'hFFFF_FFFF
                                           : sb.max_cnt_r + 1 + $urandom_range(0, 3);
      push_le(64'(cnt), 4);
      push_noise($urandom_range(0, 4));
      return;
    end
    push_le(64'(n_ent), 4);
    for (int e = 0; e < n_ent; e++) begin
      hi = (sb.max_nlen_r < 5) ? int'(sb.max_nlen_r) : 5;
      nl = 16'($urandom_range(1, hi));
      if (e == n_ent - 1 && kind == ARC_BAD_NAME_LEN) begin
        nl = ($urandom_range(0, 1) == 0 || sb.max_nlen_r == 16'hFFFF) ? 16'd0
                                                                        : sb.max_nlen_r + 16'd1;
      end
      if (e == n_ent - 1 && kind == ARC_HUGE_NAME) nl = 16'hFFFF;
      push_le(64'(nl), 2);
      if (e == n_ent - 1 && kind inside {ARC_BAD_NAME_LEN, ARC_HUGE_NAME}) begin
        push_noise($urandom_range(0, 4));
        return;
      end
      push_noise(int'(nl));
      if ($urandom_range(0, 3) == 0) t = sb.alen_r;
      else t = (sb.alen_r == '1) ? rand64() : rand64() % (sb.alen_r + 1);
      sz  = (t == '1) ? rand64() : rand64() % (t + 1);
      off = t - sz;
      if (e == n_ent - 1 && kind == ARC_BOUNDS) begin
        if ($urandom_range(0, 1) == 0 || sb.alen_r == '1) begin
          off = rand64() | 64'h8000_0000_0000_0000;
          sz  = ~off + 1 + $urandom_range(0, 255);
        end else begin
          off = rand64() % (sb.alen_r + 1);
          sz  = sb.alen_r - off + 1;
        end
      end
      push_le(off, 8);
      push_le(sz, 8);
      push_noise(4);
      if (e == n_ent - 1 && kind == ARC_BOUNDS) begin
        push_noise($urandom_range(0, 3));
        return;
      end
    end
    push_noise($urandom_range(0, 4));
  endtask

  task automatic configure_phase(input int ph);
    case (ph % 6)
      0: begin
        write_reg(CFG_KEY_SEED, rand64());
        write_reg(CFG_ARCHIVE_LENGTH, 64'($urandom_range(150, 600)));
        write_reg(CFG_MAX_ENTRIES, 64'($urandom_range(1, 4)));
        write_reg(CFG_MAX_NAME_LEN, 64'($urandom_range(2, 8)));
      end
      1: begin
        write_reg(CFG_KEY_SEED, '1);
        write_reg(CFG_ARCHIVE_LENGTH, '1);
        write_reg(CFG_MAX_ENTRIES, 64'hFFFF_FFFF);
        write_reg(CFG_MAX_NAME_LEN, 64'hFFFF);
      end
      2: begin
        write_reg(CFG_KEY_SEED, '0);
        write_reg(CFG_ARCHIVE_LENGTH, 64'($urandom_range(0, 48)));
        write_reg(CFG_MAX_ENTRIES, 64'($urandom_range(0, 3)));
        write_reg(CFG_MAX_NAME_LEN, 64'd1);
      end
      3: begin
        write_reg(CFG_KEY_SEED, rand64());
        write_reg(CFG_ARCHIVE_LENGTH, rand64() | 64'h1_0000);
        write_reg(CFG_MAX_ENTRIES, '0);
        write_reg(CFG_MAX_NAME_LEN, 64'($urandom_range(1, 65535)));
      end
      4: begin
        write_reg(CFG_KEY_SEED, rand64());
        write_reg(8'hFF, rand64());
      end
      default: begin
        write_reg(CFG_KEY_SEED, rand64());
        write_reg(CFG_ARCHIVE_LENGTH, 64'($urandom_range(100, 400)));
        write_reg(CFG_MAX_ENTRIES, 64'($urandom));
        write_reg(CFG_MAX_NAME_LEN, 64'($urandom_range(1, 65535)));
      end
    endcase
    write_reg(8'($urandom_range(CFG_MAX_NAME_LEN + 1, 8'hFF)), rand64());
    settings++;
  endtask

  initial begin
    parse_word_t got;
    int          hold;
    bit          fire;
    forever begin
      if (hold_request > 0) begin
        hold         = hold_request;
        hold_request = 0;
      end else begin
        hold = steady ? 0 : $urandom_range(0, 9);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        fire       = out_valid_o;
        got.plain  = plain_byte_o;
        got.role   = byte_role_o;
        got.ready  = entry_ready_o;
        got.index  = entry_index_o;
        got.nlen   = entry_name_length_o;
        got.offset = entry_offset_o;
        got.size   = entry_size_o;
        got.err    = error_code_o;
        got.done   = directory_done_o;
        @(posedge clk_i);
      end while (!fire);
      sb.check_result(got);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: cycle limit reached with %0d words outstanding", $time, sb.pending());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int          ph;
    int unsigned random_start;
    int unsigned phase_end;
    int          pick;
    arc_kind_e   kind;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // parse from reset state with no archive start, zero length truncates at once
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);
    drain_results();

    write_reg(CFG_ARCHIVE_LENGTH, 64'd12);
    plain_q.delete();
    push_le(64'(MAGIC_WORD), 4);
    push_le(rand64(), 4);
    push_le(64'd0, 4);
    send_archive();
    plain_q.delete();
    push_le(64'(MAGIC_WORD ^ (32'd1 << $urandom_range(0, 31))), 4);
    push_noise(1);
    send_archive();
    drain_results();

    random_start = bytes_sent;
    ph = 0;
    while (bytes_sent < random_start + RANDOM_BYTES) begin
      configure_phase(ph);
      phase_end = bytes_sent + 130;
      if (ph % 3 == 0) begin
        // hold the output long enough for the input to back up
        steady       = 1'b1;
        hold_request = 40;
        build_archive(ARC_CLEAN);
        send_archive();
      end
      while (bytes_sent < phase_end) begin
        steady = ($urandom_range(0, 3) == 0);
        pick   = $urandom_range(0, 10);
        kind   = (pick >= ARC_CLEAN) ? ARC_CLEAN : arc_kind_e'(pick);
        build_archive(kind);
        send_archive();
      end
      steady = 1'b0;
      drain_results();
      ph++;
    end

    $display("Covered %0d bytes in %0d archives over %0d register settings, %0d entries",
             bytes_sent, archives, settings, sb.entries_seen);
    $display("Error codes reached, one bit per code: %b", sb.codes_seen);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
